@@ rtl/tsle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack line editor package
// Shared widths, command codes and default sizing for the line editor.
// ----------------------------------------------------------------------------
package tsle_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int CHAR_W       = 8;
	localparam int KIND_W       = 3;

	localparam logic [KIND_W-1:0] K_INSERT    = 3'd0;
	localparam logic [KIND_W-1:0] K_BACKSPACE = 3'd1;
	localparam logic [KIND_W-1:0] K_LEFT      = 3'd2;
	localparam logic [KIND_W-1:0] K_RIGHT     = 3'd3;
	localparam logic [KIND_W-1:0] K_REVERSE   = 3'd4;
	localparam logic [KIND_W-1:0] K_DELETE    = 3'd5;
	localparam logic [KIND_W-1:0] K_FLUSH     = 3'd6;

endpackage

@@ rtl/tsle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character stack memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module tsle_ram #(
	parameter int DEPTH = tsle_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [tsle_pkg::CHAR_W-1:0] wdata,
	input  logic [AW-1:0]               raddr_a,
	input  logic [AW-1:0]               raddr_b,
	output logic [tsle_pkg::CHAR_W-1:0] rdata_a,
	output logic [tsle_pkg::CHAR_W-1:0] rdata_b
);
	import tsle_pkg::*;

	logic [CHAR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ rtl/two_stack_line_editor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stack line editor
// Line-edit buffer with a cursor, held as a left stack and a right stack.
//
// A command beat is taken when start is high and busy is low; kind selects
// insert, backspace, cursor left, cursor right, reverse left text, delete
// every copy of char_in from the left text, or flush. Busy stays high while a
// command runs. Reverse and delete each step through the left memory in their
// own loop: reverse swaps characters pairwise from both ends, delete keeps
// each one that differs from char_in. Flush sends out the line of T characters
// as result beats, one per cycle, marked by valid.
// The receiver cannot stall; every valid cycle carries one beat.
// The memories have no reset and need no clearing pass; reset empties both
// stacks and clears the drop flag, and the block is ready at once.
// ----------------------------------------------------------------------------
module two_stack_line_editor_unit #(
	parameter int CAPACITY = tsle_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tsle_pkg::KIND_W-1:0] kind,
	input  logic [tsle_pkg::CHAR_W-1:0] char_in,
	output logic                        valid,
	output logic [tsle_pkg::CHAR_W-1:0] char_out,
	output logic                        last,
	output logic                        dropped
);
	import tsle_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DISP  = 3'd1;
	localparam logic [2:0] ST_MOVE  = 3'd2;
	localparam logic [2:0] ST_REV_A = 3'd3;
	localparam logic [2:0] ST_REV_B = 3'd4;
	localparam logic [2:0] ST_DEL   = 3'd5;
	localparam logic [2:0] ST_FLUSH = 3'd6;
	localparam logic [2:0] ST_DRAIN = 3'd7;

	logic [2:0]        state_q;
	logic [CW-1:0]     lcount_q;
	logic [CW-1:0]     rcount_q;
	logic              drop_q;
	logic [KIND_W-1:0] kind_q;
	logic [CHAR_W-1:0] char_q;
	logic [AW-1:0]     lo_q;
	logic [AW-1:0]     hi_q;
	logic [CHAR_W-1:0] tmp_q;
	logic [CW-1:0]     rd_ptr_q;
	logic [CW-1:0]     wr_ptr_q;
	logic [CW-1:0]     pos_q;
	logic              pend_s1;
	logic              src_left_s1;
	logic              last_s1;
	logic              drop_s1;

	logic              l_we;
	logic [AW-1:0]     l_waddr;
	logic [CHAR_W-1:0] l_wdata;
	logic [AW-1:0]     l_raddr_a;
	logic [AW-1:0]     l_raddr_b;
	logic [CHAR_W-1:0] l_rdata_a;
	logic [CHAR_W-1:0] l_rdata_b;
	logic              r_we;
	logic [AW-1:0]     r_waddr;
	logic [CHAR_W-1:0] r_wdata;
	logic [AW-1:0]     r_raddr_a;
	logic [AW-1:0]     r_raddr_b;
	logic [CHAR_W-1:0] r_rdata_a;
	logic [CHAR_W-1:0] r_rdata_b;

	logic [CW:0]       total_w;
	logic [CW-1:0]     lcount_dec;
	logic [CW-1:0]     rcount_dec;
	logic [CW-1:0]     r_walk_idx;
	logic              keep;
	logic [CW-1:0]     wr_next;
	logic [CW-1:0]     lo_next;
	logic [CW-1:0]     hi_next;

	assign total_w    = {1'b0, lcount_q} + {1'b0, rcount_q};
	assign lcount_dec = lcount_q - CW'(1);
	assign rcount_dec = rcount_q - CW'(1);
	assign r_walk_idx = total_w[CW-1:0] - CW'(1) - pos_q;
	assign keep       = (l_rdata_a != char_q);
	assign wr_next    = wr_ptr_q + CW'(keep);
	assign lo_next    = CW'(lo_q) + CW'(1);
	assign hi_next    = CW'(hi_q) - CW'(1);

	tsle_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_left_ram (
		.clk    (clk),
		.we     (l_we),
		.waddr  (l_waddr),
		.wdata  (l_wdata),
		.raddr_a(l_raddr_a),
		.raddr_b(l_raddr_b),
		.rdata_a(l_rdata_a),
		.rdata_b(l_rdata_b)
	);

	tsle_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_right_ram (
		.clk    (clk),
		.we     (r_we),
		.waddr  (r_waddr),
		.wdata  (r_wdata),
		.raddr_a(r_raddr_a),
		.raddr_b(r_raddr_b),
		.rdata_a(r_rdata_a),
		.rdata_b(r_rdata_b)
	);

	// Memory port control for the current step.
	always_comb begin
		l_we      = 1'b0;
		l_waddr   = lcount_q[AW-1:0];
		l_wdata   = char_q;
		l_raddr_a = lcount_dec[AW-1:0];
		l_raddr_b = hi_q;
		r_we      = 1'b0;
		r_waddr   = rcount_q[AW-1:0];
		r_wdata   = l_rdata_a;
		r_raddr_a = rcount_dec[AW-1:0];
		r_raddr_b = r_walk_idx[AW-1:0];
		case (state_q)
			ST_DISP: begin
				case (kind_q)
					K_INSERT: begin
						l_we = (total_w < (CW + 1)'(CAPACITY));
					end
					K_REVERSE: begin
						l_raddr_a = '0;
						l_raddr_b = lcount_dec[AW-1:0];
					end
					K_DELETE: begin
						l_raddr_a = '0;
					end
					default: begin
					end
				endcase
			end
			ST_MOVE: begin
				if (kind_q == K_LEFT) begin
					r_we = 1'b1;
				end else begin
					l_we    = 1'b1;
					l_wdata = r_rdata_a;
				end
			end
			ST_REV_A: begin
				l_we      = 1'b1;
				l_waddr   = lo_q;
				l_wdata   = l_rdata_b;
			end
			ST_REV_B: begin
				l_we      = 1'b1;
				l_waddr   = hi_q;
				l_wdata   = tmp_q;
				l_raddr_a = lo_next[AW-1:0];
				l_raddr_b = hi_next[AW-1:0];
			end
			ST_DEL: begin
				l_we      = keep;
				l_waddr   = wr_ptr_q[AW-1:0];
				l_wdata   = l_rdata_a;
				l_raddr_a = rd_ptr_q[AW-1:0];
			end
			ST_FLUSH: begin
				l_raddr_b = pos_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer and stack pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lcount_q <= '0;
			rcount_q <= '0;
			drop_q   <= 1'b0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					state_q <= ST_IDLE;
					case (kind_q)
						K_INSERT: begin
							if (total_w < (CW + 1)'(CAPACITY)) begin
								lcount_q <= lcount_q + CW'(1);
							end else begin
								drop_q <= 1'b1;
							end
						end
						K_BACKSPACE: begin
							if (lcount_q != '0) begin
								lcount_q <= lcount_dec;
							end
						end
						K_LEFT: begin
							if (lcount_q != '0 && rcount_q < CW'(CAPACITY)) begin
								lcount_q <= lcount_dec;
								state_q  <= ST_MOVE;
							end
						end
						K_RIGHT: begin
							if (rcount_q != '0 && lcount_q < CW'(CAPACITY)) begin
								rcount_q <= rcount_dec;
								state_q  <= ST_MOVE;
							end
						end
						K_REVERSE: begin
							if (lcount_q >= CW'(2)) begin
								state_q <= ST_REV_A;
							end
						end
						K_DELETE: begin
							if (lcount_q != '0) begin
								state_q <= ST_DEL;
							end
						end
						K_FLUSH: begin
							if (total_w == '0) begin
								drop_q <= 1'b0;
							end else begin
								state_q <= ST_FLUSH;
							end
						end
						default: begin
						end
					endcase
				end
				ST_MOVE: begin
					if (kind_q == K_LEFT) begin
						rcount_q <= rcount_q + CW'(1);
					end else begin
						lcount_q <= lcount_q + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_REV_A: begin
					state_q <= ST_REV_B;
				end
				ST_REV_B: begin
					if (lo_next < hi_next) begin
						state_q <= ST_REV_A;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DEL: begin
					if (rd_ptr_q >= lcount_q) begin
						lcount_q <= wr_next;
						state_q  <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					pend_s1 <= 1'b1;
					if (pos_q == total_w[CW-1:0] - CW'(1)) begin
						lcount_q <= '0;
						rcount_q <= '0;
						drop_q   <= 1'b0;
						state_q  <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command fields, walk pointers and the result stage.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= kind;
				char_q <= char_in;
			end
			ST_DISP: begin
				lo_q     <= '0;
				hi_q     <= lcount_dec[AW-1:0];
				rd_ptr_q <= CW'(1);
				wr_ptr_q <= '0;
				pos_q    <= '0;
			end
			ST_REV_A: begin
				tmp_q <= l_rdata_a;
			end
			ST_REV_B: begin
				lo_q <= lo_next[AW-1:0];
				hi_q <= hi_next[AW-1:0];
			end
			ST_DEL: begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
				wr_ptr_q <= wr_next;
			end
			ST_FLUSH: begin
				pos_q       <= pos_q + CW'(1);
				src_left_s1 <= (pos_q < lcount_q);
				last_s1     <= (pos_q == total_w[CW-1:0] - CW'(1));
				drop_s1     <= drop_q;
			end
			default: begin
			end
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign valid    = pend_s1;
	assign char_out = src_left_s1 ? l_rdata_b : r_rdata_b;
	assign last     = last_s1;
	assign dropped  = drop_s1;

	// A result beat only appears while a flush is in progress.
	assert property (@(posedge clk) disable iff (!arst_n) valid |-> busy)
		else $error("result beat outside a flush");

	// The line never holds more characters than the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		total_w <= (CW + 1)'(CAPACITY))
		else $error("line length exceeds capacity");

	// By the final beat of a flush both stacks are empty and the flag is clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> lcount_q == '0 && rcount_q == '0 && !drop_q)
		else $error("buffer not cleared at end of flush");

	// An accepted command always makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("command beat did not start a command");

endmodule
